// ----- hdl/slpr_pkg.sv -----
// Package for the sprite line priority resolver: sizes, command codes,
// state codes and shared helpers. No dependencies.
package slpr_pkg;

  localparam int ObjectCount = 40;
  localparam int LineLimit   = 10;
  localparam int LineWidth   = 160;
  localparam int TileBytes   = 4096;
  localparam int ObjW        = 6;
  localparam int PosW        = 8;
  localparam int SelW        = 4;
  localparam int TileAddrW   = 12;
  localparam int OwnerW      = 1 + 8 + ObjW + 3;

  typedef enum logic [1:0] {
    CMD_WRITE_OBJ  = 2'd0,
    CMD_WRITE_TILE = 2'd1,
    CMD_START_LINE = 2'd2,
    CMD_READ_PIXEL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_TALL = 2'd0,
    REG_PAL0 = 2'd1,
    REG_PAL1 = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_WR_TILE, ST_LC_CLEAR, ST_SCAN_RD, ST_SCAN_CHK,
    ST_OBJ_RD, ST_OBJ_HDR, ST_PIX_OWN, ST_PIX_LO, ST_PIX_HI, ST_PIX_DEC,
    ST_OLD_LO, ST_OLD_HI, ST_OLD_DEC, ST_LINE_DONE, ST_RD_OWN, ST_RD_OBJ,
    ST_RD_LO, ST_RD_HI, ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic           valid;
    logic [7:0]     xs;
    logic [ObjW-1:0] obj;
    logic [2:0]     px;
  } owner_t;

  // Tile byte address of the low plane for object entry e on line cur.
  function automatic logic [TileAddrW-1:0] tile_addr(input logic [31:0] e,
      input logic [7:0] cur, input logic tall);
    logic [7:0] row;
    logic [7:0] tile;
    logic [7:0] h1;
    tile = tall ? (e[23:16] & 8'hFE) : e[23:16];
    h1   = tall ? 8'd15 : 8'd7;
    row  = cur + 8'd16 - e[7:0];
    if (e[30]) row = h1 - row;
    tile_addr = TileAddrW'({tile, 4'b0000} + {3'b000, row, 1'b0});
  endfunction

  function automatic logic [1:0] pix_color(input logic [7:0] lo,
      input logic [7:0] hi, input logic xflip, input logic [2:0] px);
    logic [2:0] b;
    b = xflip ? px : 3'd7 - px;
    pix_color = {hi[b], lo[b]};
  endfunction

endpackage

// ----- hdl/slpr_ram.sv -----
// Generic single-port RAM with registered read, one write port.
// No dependencies.
module slpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- hdl/slpr_regs.sv -----
// Configuration register file for the sprite line resolver.
// Depends on slpr_pkg.
module slpr_regs (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       tall,
  output logic [7:0] pal0,
  output logic [7:0] pal1
);
  always_ff @(posedge clk) begin
    if (rst) begin
      tall <= 1'b0;
      pal0 <= '0;
      pal1 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slpr_pkg::REG_TALL: tall <= cfg_data[0];
        slpr_pkg::REG_PAL0: pal0 <= cfg_data;
        slpr_pkg::REG_PAL1: pal1 <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

// ----- hdl/sprite_line_priority_resolver.sv -----
// Top level of the sprite line priority resolver: sequencer around the object
// table, tile, selection and line owner memories. Depends on slpr_pkg,
// slpr_ram and slpr_regs.
//
// After reset the block zeroes tile memory (and the object table and line
// buffer in parallel) with busy high. Then it serves commands: object write,
// tile write, pixel read and line start. A line start clears the line buffer,
// scans the object table entries and resolves each object pixel of every
// selected object; each color lookup reads the single tile memory port twice,
// and two more reads are made when the current owner's color must be looked
// up as well. Results appear for one cycle with valid high and cannot be
// stalled.
module sprite_line_priority_resolver (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [5:0]  entry_index,
  input  logic [7:0]  y_pos,
  input  logic [7:0]  x_pos,
  input  logic [7:0]  tile_number,
  input  logic [7:0]  attr_flags,
  input  logic [11:0] tile_address,
  input  logic [7:0]  tile_byte,
  input  logic [7:0]  line_number,
  input  logic [7:0]  pixel_x,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        valid,
  output logic [3:0]  objects_found,
  output logic [1:0]  color_id,
  output logic [7:0]  palette,
  output logic        visible
);
  localparam int OcW = 6;
  localparam int LwW = 8;

  slpr_pkg::state_t state, state_next;

  logic       tall;
  logic [7:0] pal0, pal1;

  slpr_regs u_regs (
    .clk, .rst, .cfg_valid(cfg_valid & cfg_ready), .cfg_index, .cfg_data,
    .tall, .pal0, .pal1
  );
  assign cfg_ready = 1'b1;

  // memories
  logic           ot_we;
  logic [OcW-1:0] ot_addr;
  logic [31:0]    ot_wdata, ot_rdata;
  logic           tm_we;
  logic [11:0]    tm_addr;
  logic [7:0]     tm_wdata, tm_rdata;
  logic           lo_we;
  logic [LwW-1:0] lo_addr;
  slpr_pkg::owner_t lo_wdata, lo_rdata;
  logic           so_we;
  logic [3:0]     so_addr;
  logic [5:0]     so_wdata, so_rdata;

  slpr_ram #(.Width(32), .Depth(slpr_pkg::ObjectCount)) u_obj (
    .clk, .we(ot_we), .addr(ot_addr), .wdata(ot_wdata), .rdata(ot_rdata));
  slpr_ram #(.Width(8), .Depth(slpr_pkg::TileBytes)) u_tile (
    .clk, .we(tm_we), .addr(tm_addr), .wdata(tm_wdata), .rdata(tm_rdata));
  slpr_ram #(.Width(slpr_pkg::OwnerW), .Depth(slpr_pkg::LineWidth)) u_line (
    .clk, .we(lo_we), .addr(lo_addr), .wdata(lo_wdata), .rdata(lo_rdata));
  slpr_ram #(.Width(6), .Depth(16)) u_sel (
    .clk, .we(so_we), .addr(so_addr), .wdata(so_wdata), .rdata(so_rdata));

  // working registers
  logic [11:0] cnt, cnt_next;
  logic [1:0]  cmd_q, cmd_q_next;
  logic [7:0]  line_q, line_q_next;
  logic [7:0]  cur_line, cur_line_next;
  logic [3:0]  sel_cnt, sel_cnt_next;
  logic [3:0]  k, k_next;
  logic [5:0]  obj, obj_next;
  logic [31:0] ent, ent_next;
  logic [2:0]  p, p_next;
  logic [7:0]  lo_b, lo_b_next;
  logic [1:0]  new_c, new_c_next;
  slpr_pkg::owner_t own, own_next;
  logic [11:0] ta_q, ta_q_next;
  logic [7:0]  tb_q, tb_q_next;
  logic [7:0]  px_q, px_q_next;
  logic        out_v;
  logic [3:0]  out_found;
  logic [1:0]  out_col;
  logic [7:0]  out_pal;
  logic        out_vis;

  logic [8:0] pos9;
  logic [8:0] l16;
  logic [8:0] yh;
  logic       covers;
  logic [1:0] c_now;

  function automatic logic [7:0] pos9x(input logic [7:0] xs, input logic [2:0] pp);
    pos9x = xs + {5'd0, pp} - 8'd8;
  endfunction

  always_comb begin
    pos9   = {1'b0, ent[15:8]} + {6'd0, p} - 9'd8;
    l16    = {1'b0, line_q} + 9'd16;
    yh     = {1'b0, ot_rdata[7:0]} + (tall ? 9'd16 : 9'd8);
    covers = (l16 >= {1'b0, ot_rdata[7:0]}) && (l16 < yh);
    c_now  = slpr_pkg::pix_color(lo_b, tm_rdata, ent[29], own.px);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= slpr_pkg::ST_CLEAR;
      cnt      <= '0;
      cur_line <= '0;
      sel_cnt  <= '0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      cur_line <= cur_line_next;
      sel_cnt  <= sel_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q  <= cmd_q_next;
    line_q <= line_q_next;
    k      <= k_next;
    obj    <= obj_next;
    ent    <= ent_next;
    p      <= p_next;
    lo_b   <= lo_b_next;
    new_c  <= new_c_next;
    own    <= own_next;
    ta_q   <= ta_q_next;
    tb_q   <= tb_q_next;
    px_q   <= px_q_next;
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cur_line_next = cur_line;
    sel_cnt_next  = sel_cnt;
    cmd_q_next    = cmd_q;
    line_q_next   = line_q;
    k_next        = k;
    obj_next      = obj;
    ent_next      = ent;
    p_next        = p;
    lo_b_next     = lo_b;
    new_c_next    = new_c;
    own_next      = own;
    ta_q_next     = ta_q;
    tb_q_next     = tb_q;
    px_q_next     = px_q;
    busy          = 1'b1;
    ot_we = 1'b0; ot_addr = obj; ot_wdata = '0;
    tm_we = 1'b0; tm_addr = '0;  tm_wdata = '0;
    lo_we = 1'b0; lo_addr = '0;  lo_wdata = '0;
    so_we = 1'b0; so_addr = k;   so_wdata = obj;
    out_v = 1'b0; out_found = '0; out_col = '0; out_pal = '0; out_vis = 1'b0;
    unique case (state)
      slpr_pkg::ST_CLEAR: begin
        tm_we = 1'b1; tm_addr = cnt;
        if (cnt < 12'(slpr_pkg::ObjectCount)) begin
          ot_we = 1'b1; ot_addr = cnt[OcW-1:0];
        end
        if (cnt < 12'(slpr_pkg::LineWidth)) begin
          lo_we = 1'b1; lo_addr = cnt[LwW-1:0];
        end
        cnt_next = cnt + 12'd1;
        if (cnt == 12'(slpr_pkg::TileBytes - 1)) state_next = slpr_pkg::ST_IDLE;
      end
      slpr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_q_next  = cmd;
          line_q_next = line_number;
          ta_q_next   = tile_address;
          tb_q_next   = tile_byte;
          px_q_next   = pixel_x;
          unique case (slpr_pkg::cmd_t'(cmd))
            slpr_pkg::CMD_WRITE_OBJ: begin
              if (entry_index < 6'(slpr_pkg::ObjectCount)) begin
                ot_we = 1'b1; ot_addr = entry_index;
                ot_wdata = {attr_flags, tile_number, x_pos, y_pos};
              end
              state_next = slpr_pkg::ST_LINE_DONE;
            end
            slpr_pkg::CMD_WRITE_TILE: state_next = slpr_pkg::ST_WR_TILE;
            slpr_pkg::CMD_START_LINE: begin
              cnt_next   = '0;
              state_next = slpr_pkg::ST_LC_CLEAR;
            end
            slpr_pkg::CMD_READ_PIXEL: state_next = slpr_pkg::ST_RD_OWN;
            default: ;
          endcase
        end
      end
      slpr_pkg::ST_WR_TILE: begin
        tm_we = 1'b1; tm_addr = ta_q; tm_wdata = tb_q;
        state_next = slpr_pkg::ST_IDLE;
      end
      slpr_pkg::ST_LC_CLEAR: begin
        lo_we = 1'b1; lo_addr = cnt[LwW-1:0];
        cnt_next = cnt + 12'd1;
        if (cnt == 12'(slpr_pkg::LineWidth - 1)) begin
          cur_line_next = line_q;
          sel_cnt_next  = '0;
          obj_next      = '0;
          state_next    = slpr_pkg::ST_SCAN_RD;
        end
      end
      slpr_pkg::ST_SCAN_RD: begin
        ot_addr    = obj;
        state_next = slpr_pkg::ST_SCAN_CHK;
      end
      slpr_pkg::ST_SCAN_CHK: begin
        if (covers) begin
          so_we = 1'b1; so_addr = sel_cnt; so_wdata = obj;
          sel_cnt_next = sel_cnt + 4'd1;
        end
        obj_next = obj + 6'd1;
        if (obj == 6'(slpr_pkg::ObjectCount - 1) ||
            (covers && sel_cnt == 4'(slpr_pkg::LineLimit - 1))) begin
          k_next     = '0;
          state_next = slpr_pkg::ST_OBJ_RD;
        end else begin
          state_next = slpr_pkg::ST_SCAN_RD;
        end
      end
      slpr_pkg::ST_OBJ_RD: begin
        if (k == sel_cnt) begin
          state_next = slpr_pkg::ST_LINE_DONE;
        end else begin
          so_addr    = k;
          state_next = slpr_pkg::ST_OBJ_HDR;
        end
      end
      slpr_pkg::ST_OBJ_HDR: begin
        obj_next = so_rdata;
        ot_addr  = so_rdata;
        p_next   = '0;
        state_next = slpr_pkg::ST_PIX_OWN;
      end
      slpr_pkg::ST_PIX_OWN: begin
        if (p == 3'd0) ent_next = ot_rdata;
        lo_addr = pos9x((p == 3'd0) ? ot_rdata[15:8] : ent[15:8], p);
        state_next = slpr_pkg::ST_PIX_LO;
      end
      slpr_pkg::ST_PIX_LO: begin
        own_next = lo_rdata;
        if (pos9[8] || pos9 >= 9'(slpr_pkg::LineWidth)) begin
          state_next = slpr_pkg::ST_PIX_DEC;
          new_c_next = '0;
        end else begin
          tm_addr = slpr_pkg::tile_addr(ent, cur_line, tall);
          state_next = slpr_pkg::ST_PIX_HI;
        end
      end
      slpr_pkg::ST_PIX_HI: begin
        lo_b_next = tm_rdata;
        tm_addr = slpr_pkg::tile_addr(ent, cur_line, tall) + 12'd1;
        state_next = slpr_pkg::ST_OLD_LO;
      end
      slpr_pkg::ST_OLD_LO: begin
        new_c_next = slpr_pkg::pix_color(lo_b, tm_rdata, ent[29], p);
        ot_addr = own.obj;
        state_next = slpr_pkg::ST_PIX_DEC;
      end
      slpr_pkg::ST_PIX_DEC: begin
        state_next = slpr_pkg::ST_PIX_OWN;
        if (!(pos9[8] || pos9 >= 9'(slpr_pkg::LineWidth))) begin
          lo_addr  = pos9[7:0];
          lo_wdata = '{valid: 1'b1, xs: ent[15:8], obj: obj, px: p};
          if (!own.valid) begin
            lo_we = 1'b1;
          end else if (ent[15:8] < own.xs) begin
            lo_we = (new_c != 2'd0);
          end else begin
            // old owner color needs two tile reads
            tm_addr = slpr_pkg::tile_addr(ot_rdata, cur_line, tall);
            ent_next = ot_rdata;
            own_next.xs = ent[15:8];
            state_next = slpr_pkg::ST_OLD_HI;
          end
        end
        if (state_next == slpr_pkg::ST_PIX_OWN) begin
          p_next = p + 3'd1;
          if (p == 3'd7) begin
            k_next = k + 4'd1;
            state_next = slpr_pkg::ST_OBJ_RD;
          end else begin
            ot_addr = obj;
          end
        end
      end
      slpr_pkg::ST_OLD_HI: begin
        // ent holds the old owner's entry; own.xs holds the new X
        lo_b_next = tm_rdata;
        tm_addr = slpr_pkg::tile_addr(ent, cur_line, tall) + 12'd1;
        ot_addr = obj;
        state_next = slpr_pkg::ST_OLD_DEC;
      end
      slpr_pkg::ST_OLD_DEC: begin
        if (c_now == 2'd0) begin
          lo_we = 1'b1; lo_addr = pos9x(own.xs, p);
          lo_wdata = '{valid: 1'b1, xs: own.xs, obj: obj, px: p};
        end
        state_next = slpr_pkg::ST_PIX_OWN;
        p_next = p + 3'd1;
        ent_next = ot_rdata;
        if (p == 3'd7) begin
          k_next = k + 4'd1;
          state_next = slpr_pkg::ST_OBJ_RD;
        end else begin
          ot_addr = obj;
        end
      end
      slpr_pkg::ST_LINE_DONE: begin
        if (cmd_q == slpr_pkg::CMD_START_LINE) begin
          out_v = 1'b1; out_found = sel_cnt;
        end
        state_next = slpr_pkg::ST_IDLE;
      end
      slpr_pkg::ST_RD_OWN: begin
        lo_addr = px_q;
        state_next = slpr_pkg::ST_RD_OBJ;
      end
      slpr_pkg::ST_RD_OBJ: begin
        own_next = lo_rdata;
        ot_addr  = lo_rdata.obj;
        if (px_q >= 8'(slpr_pkg::LineWidth) || !lo_rdata.valid) begin
          out_v = 1'b1;
          state_next = slpr_pkg::ST_IDLE;
        end else begin
          state_next = slpr_pkg::ST_RD_LO;
        end
      end
      slpr_pkg::ST_RD_LO: begin
        ent_next = ot_rdata;
        tm_addr = slpr_pkg::tile_addr(ot_rdata, cur_line, tall);
        state_next = slpr_pkg::ST_RD_HI;
      end
      slpr_pkg::ST_RD_HI: begin
        lo_b_next = tm_rdata;
        tm_addr = slpr_pkg::tile_addr(ent, cur_line, tall) + 12'd1;
        state_next = slpr_pkg::ST_RD_OUT;
      end
      slpr_pkg::ST_RD_OUT: begin
        out_v   = 1'b1;
        out_col = c_now;
        out_pal = ent[28] ? pal1 : pal0;
        out_vis = (c_now != 2'd0) && !ent[31];
        state_next = slpr_pkg::ST_IDLE;
      end
      default: state_next = slpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= out_v;
    end
    objects_found <= out_found;
    color_id      <= out_col;
    palette       <= out_pal;
    visible       <= out_vis;
  end

  assert property (@(posedge clk) disable iff (rst) sel_cnt <= 4'(slpr_pkg::LineLimit))
    else $error("selection count above limit");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");
  assert property (@(posedge clk) disable iff (rst) valid |-> !$past(valid))
    else $error("result held longer than one cycle");
  assert property (@(posedge clk) disable iff (rst) !valid || visible == 1'b0 || color_id != 2'd0)
    else $error("visible with transparent colour");
endmodule
